// ----- rtl/core/ptm_pkg.sv -----
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared constants, codes and controller/datapath interface types for the
// four-level page table mapper.
// ----------------------------------------------------------------------------
package ptm_pkg;

   // Table memory geometry.
   localparam int TABLE_PAGES      = 64;
   localparam int ENTRIES_PER_PAGE = 512;
   localparam int INDEX_BITS       = $clog2(ENTRIES_PER_PAGE);
   localparam int PAGE_BITS        = $clog2(TABLE_PAGES);
   localparam int PAGE_CNT_BITS    = $clog2(TABLE_PAGES + 1);
   localparam int WORD_ADDR_BITS   = PAGE_BITS + INDEX_BITS;
   localparam int TABLE_WORDS      = TABLE_PAGES * ENTRIES_PER_PAGE;

   // Field widths fixed by the interface.
   localparam int VA_BITS      = 48;
   localparam int PA_BITS      = 52;
   localparam int FLAG_BITS    = 12;
   localparam int RPAGE_BITS   = 6;
   localparam int WORD_BITS    = 64;
   localparam int USED_BITS    = 7;
   localparam int FRAME_BITS   = 36;   // address bits 47:12
   localparam int LEVEL_BITS   = 2;

   localparam logic [LEVEL_BITS-1:0] LAST_UPPER_LEVEL = 2'd2;
   localparam logic [FLAG_BITS-1:0]  LINK_FLAGS       = 12'h003;

   // Operation codes on req_func.
   typedef enum logic {
      FUNC_MAP  = 1'b0,
      FUNC_READ = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK          = 2'd0,
      STAT_NO_PAGES    = 2'd1,
      STAT_UNALLOCATED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      VAL_ZERO = 2'd0,
      VAL_LEAF = 2'd1,
      VAL_WORD = 2'd2
   } val_sel_type;

   typedef enum logic [3:0] {
      ST_CLEAR_ROOT,
      ST_IDLE,
      ST_READ_CHECK,
      ST_READ_DATA,
      ST_WALK_READ,
      ST_WALK_CALC,
      ST_WALK_DECIDE,
      ST_CLEAR_PAGE,
      ST_LEAF,
      ST_RESPOND
   } fsm_state_type;

   typedef struct packed {
      logic                  capture;
      logic                  clr_step;
      logic                  rd_upper;
      logic                  rd_word;
      logic                  calc;
      logic                  link_write;
      logic                  descend;
      logic                  leaf_write;
      logic                  set_result;
      status_type            res_status;
      val_sel_type           res_sel;
      logic                  respond;
      logic [LEVEL_BITS-1:0] level;
   } cmd_type;

   typedef struct packed {
      logic read_oob;
      logic entry_present;
      logic pages_full;
      logic link_stale;
      logic clr_last;
      logic out_free;
   } sts_type;

endpackage

// ----- rtl/core/ptm_datapath.sv -----
// ----------------------------------------------------------------------------
// ptm_datapath
// Table memory, bump allocator, walk registers and the result register.
// ----------------------------------------------------------------------------
module ptm_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [ptm_pkg::PA_BITS-1:0]         csr_write_data,
   input  logic [ptm_pkg::VA_BITS-1:0]         req_virt_addr,
   input  logic [ptm_pkg::PA_BITS-1:0]         req_phys_addr,
   input  logic [ptm_pkg::FLAG_BITS-1:0]       req_flags,
   input  logic [ptm_pkg::RPAGE_BITS-1:0]      req_read_page,
   input  logic [ptm_pkg::INDEX_BITS-1:0]      req_read_index,
   input  ptm_pkg::cmd_type                    cmd,
   output ptm_pkg::sts_type                    sts,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [ptm_pkg::WORD_BITS-1:0]       rsp_entry_value,
   output logic [ptm_pkg::USED_BITS-1:0]       rsp_pages_used
);

   // Table memory with one write and one registered read port.
   logic [ptm_pkg::WORD_BITS-1:0] mem [ptm_pkg::TABLE_WORDS];

   logic [ptm_pkg::FRAME_BITS-1:0]     base_ff;
   logic [ptm_pkg::VA_BITS-1:0]        va_ff;
   logic [ptm_pkg::FRAME_BITS-1:0]     pa_frame_ff;
   logic [ptm_pkg::FLAG_BITS-1:0]      flags_ff;
   logic [ptm_pkg::RPAGE_BITS-1:0]     rpage_ff;
   logic [ptm_pkg::INDEX_BITS-1:0]     rindex_ff;
   logic [ptm_pkg::PAGE_CNT_BITS-1:0]  next_free_ff;
   logic [ptm_pkg::PAGE_BITS-1:0]      cur_page_ff;
   logic [ptm_pkg::PAGE_BITS-1:0]      clr_page_ff;
   logic [ptm_pkg::INDEX_BITS-1:0]     clr_cnt_ff;
   logic [ptm_pkg::WORD_BITS-1:0]      rd_data_ff;
   logic [ptm_pkg::FRAME_BITS-1:0]     off_ff;
   logic [ptm_pkg::FRAME_BITS-1:0]     link_frame_ff;
   ptm_pkg::status_type                res_status_ff;
   logic [ptm_pkg::WORD_BITS-1:0]      res_value_ff;
   logic                               rsp_valid_ff;
   ptm_pkg::status_type                rsp_status_ff;
   logic [ptm_pkg::WORD_BITS-1:0]      rsp_value_ff;
   logic [ptm_pkg::USED_BITS-1:0]      rsp_used_ff;

   logic [ptm_pkg::INDEX_BITS-1:0]     level_idx;
   logic [ptm_pkg::INDEX_BITS-1:0]     leaf_idx;
   logic [ptm_pkg::WORD_BITS-1:0]      leaf_value;
   logic [ptm_pkg::WORD_BITS-1:0]      link_value;
   logic                               mem_we;
   logic [ptm_pkg::WORD_ADDR_BITS-1:0] mem_waddr;
   logic [ptm_pkg::WORD_BITS-1:0]      mem_wdata;
   logic                               mem_re;
   logic [ptm_pkg::WORD_ADDR_BITS-1:0] mem_raddr;
   logic [ptm_pkg::WORD_BITS-1:0]      res_value_in;

   always_comb begin
      case (cmd.level)
         2'd0:    level_idx = va_ff[47:39];
         2'd1:    level_idx = va_ff[38:30];
         default: level_idx = va_ff[29:21];
      endcase
   end

   assign leaf_idx   = va_ff[20:12];
   assign leaf_value = {16'd0, pa_frame_ff, flags_ff};
   assign link_value = {16'd0, link_frame_ff, ptm_pkg::LINK_FLAGS};

   // Write port: page clearing, upper-level links and the leaf share it.
   always_comb begin
      mem_we    = cmd.clr_step | cmd.link_write | cmd.leaf_write;
      mem_waddr = {clr_page_ff, clr_cnt_ff};
      mem_wdata = '0;
      if (cmd.link_write) begin
         mem_waddr = {cur_page_ff, level_idx};
         mem_wdata = link_value;
      end else if (cmd.leaf_write) begin
         mem_waddr = {cur_page_ff, leaf_idx};
         mem_wdata = leaf_value;
      end
   end

   always_comb begin
      mem_re    = cmd.rd_upper | cmd.rd_word;
      mem_raddr = {cur_page_ff, level_idx};
      if (cmd.rd_word) begin
         mem_raddr = {ptm_pkg::PAGE_BITS'(rpage_ff), rindex_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   // Captured request fields.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         va_ff       <= req_virt_addr;
         pa_frame_ff <= req_phys_addr[47:12];
         flags_ff    <= req_flags;
         rpage_ff    <= req_read_page;
         rindex_ff   <= req_read_index;
      end
   end

   // Offset of a present link from the table base, and the link for a new page.
   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         off_ff        <= rd_data_ff[47:12] - base_ff;
         link_frame_ff <= base_ff + ptm_pkg::FRAME_BITS'(next_free_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cur_page_ff <= '0;
      end else if (cmd.link_write) begin
         cur_page_ff <= next_free_ff[ptm_pkg::PAGE_BITS-1:0];
      end else if (cmd.descend) begin
         cur_page_ff <= off_ff[ptm_pkg::PAGE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         next_free_ff <= ptm_pkg::PAGE_CNT_BITS'(1);
         clr_page_ff  <= '0;
         clr_cnt_ff   <= '0;
      end else begin
         if (csr_write_enable) begin
            base_ff <= csr_write_data[47:12];
         end
         if (cmd.link_write) begin
            next_free_ff <= next_free_ff + ptm_pkg::PAGE_CNT_BITS'(1);
            clr_page_ff  <= next_free_ff[ptm_pkg::PAGE_BITS-1:0];
            clr_cnt_ff   <= '0;
         end else if (cmd.clr_step) begin
            clr_cnt_ff <= clr_cnt_ff + ptm_pkg::INDEX_BITS'(1);
         end
      end
   end

   always_comb begin
      case (cmd.res_sel)
         ptm_pkg::VAL_LEAF: res_value_in = leaf_value;
         ptm_pkg::VAL_WORD: res_value_in = rd_data_ff;
         default:           res_value_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.set_result) begin
         res_status_ff <= cmd.res_status;
         res_value_ff  <= res_value_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.respond) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_used_ff   <= ptm_pkg::USED_BITS'(next_free_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_pages_used  = rsp_used_ff;

   always_comb begin
      sts.read_oob      = ptm_pkg::PAGE_CNT_BITS'(rpage_ff) >= next_free_ff;
      sts.entry_present = rd_data_ff[0];
      sts.pages_full    = next_free_ff >= ptm_pkg::PAGE_CNT_BITS'(ptm_pkg::TABLE_PAGES);
      sts.link_stale    = off_ff >= ptm_pkg::FRAME_BITS'(next_free_ff);
      sts.clr_last      = clr_cnt_ff == ptm_pkg::INDEX_BITS'(ptm_pkg::ENTRIES_PER_PAGE - 1);
      sts.out_free      = !rsp_valid_ff || !rsp_stall;
   end

   a_next_free_range: assert property (@(posedge clock) disable iff (reset)
      (next_free_ff >= ptm_pkg::PAGE_CNT_BITS'(1)) &&
      (next_free_ff <= ptm_pkg::PAGE_CNT_BITS'(ptm_pkg::TABLE_PAGES)))
      else $error("allocator count out of range");

   a_alloc_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.link_write |-> !sts.pages_full)
      else $error("page allocated with table memory full");

   a_alloc_only_on_link: assert property (@(posedge clock) disable iff (reset)
      !cmd.link_write |=> $stable(next_free_ff))
      else $error("allocator moved without a link write");

   a_respond_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |-> sts.out_free)
      else $error("result register overwritten while held");

endmodule

// ----- rtl/core/ptm_controller.sv -----
// ----------------------------------------------------------------------------
// ptm_controller
// Sequencer for root clearing, table walks, page allocation and reads.
// ----------------------------------------------------------------------------
module ptm_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_func,
   output logic             req_stall,
   input  ptm_pkg::sts_type sts,
   output ptm_pkg::cmd_type cmd
);

   ptm_pkg::fsm_state_type          state_ff;
   ptm_pkg::fsm_state_type          state_in;
   logic [ptm_pkg::LEVEL_BITS-1:0]  level_ff;
   logic [ptm_pkg::LEVEL_BITS-1:0]  level_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptm_pkg::ST_CLEAR_ROOT;
         level_ff <= '0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      level_in       = level_ff;
      cmd            = '0;
      cmd.res_status = ptm_pkg::STAT_OK;
      cmd.res_sel    = ptm_pkg::VAL_ZERO;
      cmd.level      = level_ff;
      req_stall      = 1'b1;
      unique case (state_ff)
         ptm_pkg::ST_CLEAR_ROOT: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = ptm_pkg::ST_IDLE;
            end
         end
         ptm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               level_in    = '0;
               state_in    = (req_func == ptm_pkg::FUNC_READ) ? ptm_pkg::ST_READ_CHECK
                                                              : ptm_pkg::ST_WALK_READ;
            end
         end
         ptm_pkg::ST_READ_CHECK: begin
            if (sts.read_oob) begin
               cmd.set_result = 1'b1;
               cmd.res_status = ptm_pkg::STAT_UNALLOCATED;
               state_in       = ptm_pkg::ST_RESPOND;
            end else begin
               cmd.rd_word = 1'b1;
               state_in    = ptm_pkg::ST_READ_DATA;
            end
         end
         ptm_pkg::ST_READ_DATA: begin
            cmd.set_result = 1'b1;
            cmd.res_sel    = ptm_pkg::VAL_WORD;
            state_in       = ptm_pkg::ST_RESPOND;
         end
         ptm_pkg::ST_WALK_READ: begin
            cmd.rd_upper = 1'b1;
            state_in     = ptm_pkg::ST_WALK_CALC;
         end
         ptm_pkg::ST_WALK_CALC: begin
            cmd.calc = 1'b1;
            state_in = ptm_pkg::ST_WALK_DECIDE;
         end
         ptm_pkg::ST_WALK_DECIDE: begin
            if (sts.entry_present) begin
               if (sts.link_stale) begin
                  cmd.set_result = 1'b1;
                  cmd.res_status = ptm_pkg::STAT_UNALLOCATED;
                  state_in       = ptm_pkg::ST_RESPOND;
               end else begin
                  cmd.descend = 1'b1;
                  if (level_ff == ptm_pkg::LAST_UPPER_LEVEL) begin
                     state_in = ptm_pkg::ST_LEAF;
                  end else begin
                     level_in = level_ff + ptm_pkg::LEVEL_BITS'(1);
                     state_in = ptm_pkg::ST_WALK_READ;
                  end
               end
            end else if (sts.pages_full) begin
               cmd.set_result = 1'b1;
               cmd.res_status = ptm_pkg::STAT_NO_PAGES;
               state_in       = ptm_pkg::ST_RESPOND;
            end else begin
               cmd.link_write = 1'b1;
               state_in       = ptm_pkg::ST_CLEAR_PAGE;
            end
         end
         ptm_pkg::ST_CLEAR_PAGE: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               if (level_ff == ptm_pkg::LAST_UPPER_LEVEL) begin
                  state_in = ptm_pkg::ST_LEAF;
               end else begin
                  level_in = level_ff + ptm_pkg::LEVEL_BITS'(1);
                  state_in = ptm_pkg::ST_WALK_READ;
               end
            end
         end
         ptm_pkg::ST_LEAF: begin
            cmd.leaf_write = 1'b1;
            cmd.set_result = 1'b1;
            cmd.res_sel    = ptm_pkg::VAL_LEAF;
            state_in       = ptm_pkg::ST_RESPOND;
         end
         ptm_pkg::ST_RESPOND: begin
            if (sts.out_free) begin
               cmd.respond = 1'b1;
               state_in    = ptm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptm_pkg::ST_IDLE;
         end
      endcase
   end

   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clr_step, cmd.link_write, cmd.leaf_write}))
      else $error("two sources drive the table write port");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= ptm_pkg::LAST_UPPER_LEVEL)
      else $error("walk level beyond the last upper level");

   a_capture_on_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> (req_valid && !req_stall))
      else $error("request captured without a handshake");

endmodule

// ----- rtl/core/four_level_page_table_mapper.sv -----
// ----------------------------------------------------------------------------
// four_level_page_table_mapper
// Builds x86-64 four-level page tables in an internal table memory.
//
// The block keeps 64 table pages of 512 64-bit entries; page 0 is the root.
// A map transaction walks the three upper levels with virtual address bits
// 47:39, 38:30 and 29:21, links a freshly cleared page wherever an entry is
// not present (link = table_base + page * 4096, present and write set), and
// writes the leaf entry (physical frame ORed with the 12 flag bits) at bits
// 20:12. A read transaction returns one word of an allocated page. After
// reset the root page is cleared, during which req_stall is held high;
// configuration writes are taken at any time. A read checks the page
// against the allocator and reads the word only if the page is allocated.
// A map takes a table read, an offset and link computation and a decision
// per upper level, then writes the leaf; every new page is cleared one
// entry per cycle through the single write port of the table memory. The
// block returns to idle and accepts the next transaction once the result
// enters the output register, which can hold a result while the block works
// on the next transaction. Status 1 reports that the table memory is full
// (links already made stay in place); status 2 reports a read of an
// unallocated page or a present link that leads to one.
// ----------------------------------------------------------------------------
module four_level_page_table_mapper (
   input  logic                           clock,
   input  logic                           reset,
   // Configuration
   input  logic                           csr_write_enable,
   input  logic [ptm_pkg::PA_BITS-1:0]    csr_write_data,
   // Request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_func,
   input  logic [ptm_pkg::VA_BITS-1:0]    req_virt_addr,
   input  logic [ptm_pkg::PA_BITS-1:0]    req_phys_addr,
   input  logic [ptm_pkg::FLAG_BITS-1:0]  req_flags,
   input  logic [ptm_pkg::RPAGE_BITS-1:0] req_read_page,
   input  logic [ptm_pkg::INDEX_BITS-1:0] req_read_index,
   // Response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [ptm_pkg::WORD_BITS-1:0]  rsp_entry_value,
   output logic [ptm_pkg::USED_BITS-1:0]  rsp_pages_used
);

   // Commands from the sequencer and status back from the datapath.
   ptm_pkg::cmd_type cmd;
   ptm_pkg::sts_type sts;

   // The controller owns the walk sequence and the request handshake.
   ptm_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the table memory, allocator and output register.
   ptm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_virt_addr    (req_virt_addr),
      .req_phys_addr    (req_phys_addr),
      .req_flags        (req_flags),
      .req_read_page    (req_read_page),
      .req_read_index   (req_read_index),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_entry_value  (rsp_entry_value),
      .rsp_pages_used   (rsp_pages_used)
   );

endmodule
